@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Strict-priority packet queues: shared definitions
// Field widths, stream packing offsets, status and function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default sizing of the queue store
    localparam int MAX_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;

    // Configuration register
    localparam int            CFG_W         = 4;
    localparam logic [CFG_W-1:0] CFG_LEVELS_RST = 4'd8;

    // Descriptor field widths
    localparam int PRIO_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;
    localparam int LEVEL_W = 3;
    localparam int STAT_W  = 2;

    // Function codes (slave tuser)
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Status codes (master tuser)
    localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Stream widths
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = STAT_W;

    // Slave tdata offsets
    localparam int S_PRIO_LO  = 0;
    localparam int S_SRCA_LO  = 8;
    localparam int S_SRCP_LO  = 40;
    localparam int S_DSTA_LO  = 56;
    localparam int S_DSTP_LO  = 88;
    localparam int S_PROTO_LO = 104;

    // Master tdata offsets
    localparam int M_LEVEL_LO = 0;
    localparam int M_PRIO_LO  = 3;
    localparam int M_SRCA_LO  = 11;
    localparam int M_SRCP_LO  = 43;
    localparam int M_DSTA_LO  = 59;
    localparam int M_DSTP_LO  = 91;
    localparam int M_PROTO_LO = 107;
    localparam int M_ESC_BIT  = 115;

    // One stored descriptor
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [ADDR_W-1:0]  src_addr;
        logic [PORT_W-1:0]  src_port;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PORT_W-1:0]  dst_port;
        logic [PROTO_W-1:0] proto;
    } t_desc;

    // Control carried from the accept stage to the result stage
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LEVEL_W-1:0] level;
    } t_s1_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/strict_priority_packet_queues.sv @@
// ----------------------------------------------------------------------------
// Strict-priority packet queues
// One bounded descriptor FIFO per priority level, served lowest level first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction. tuser selects enqueue
//   or dequeue; tdata carries the requested priority and the descriptor.
//   Every command yields exactly one result transaction on the master stream:
//   enqueued or dropped (level full) with the clamped level, or dequeued with
//   the descriptor of the head of the lowest non-empty level, or all empty.
//   The cfg channel writes active_levels; it is always ready and must only
//   be written while no command is in flight.
// Throughput and pipeline:
//   One command per cycle while the master takes results. Queue pointers and
//   the store are updated and read at the accept edge; the read stage holds
//   the status and the registered store read until they are formatted into
//   the output register.
// Reset:
//   Clears head and tail pointers, fill counts and the pipeline valids, and
//   sets active_levels to 8. Store contents are left as they are; an entry
//   is only read after it has been written.
// Stall:
//   A stalled master holds the output register; one more command may be
//   held in the read stage, after which o_s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_packet_queues #(
    parameter int MAX_LEVELS  = spq_pkg::MAX_LEVELS_DEF,
    parameter int LEVEL_DEPTH = spq_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Commands
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // priority_req[7:0], src_addr[39:8], src_port[55:40], dst_addr[87:56],
    // dst_port[103:88], proto[111:104]
    input  wire logic [spq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // func[0]
    input  wire logic [spq_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // Results
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // level[2:0], out_priority[10:3], out_src_addr[42:11], out_src_port[58:43],
    // out_dst_addr[90:59], out_dst_port[106:91], out_proto[114:107],
    // escalate[115], zero[119:116]
    output logic [spq_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // status[1:0]
    output logic [spq_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,
    // Configuration: active_levels
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [spq_pkg::CFG_W-1:0]      i_cfg_data
);
    import spq_pkg::*;

    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int FILL_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ENTRIES = MAX_LEVELS * LEVEL_DEPTH;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Queue state
    logic [CFG_W-1:0]  r_active_levels;
    logic [PTR_W-1:0]  r_head [MAX_LEVELS];
    logic [PTR_W-1:0]  r_tail [MAX_LEVELS];
    logic [FILL_W-1:0] r_fill [MAX_LEVELS];

    // Descriptor store, one region of LEVEL_DEPTH entries per level
    t_desc r_store [ENTRIES];
    t_desc r_rd_data;

    // Pipeline
    logic                 r_s1_valid;
    t_s1_ctrl             r_s1;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata;
    logic [M_TUSER_W-1:0] r_out_tuser;

    logic s1_advance;
    logic accept;
    logic is_enq;
    logic is_deq;

    // Enqueue path
    logic [PRIO_W-1:0] prio_req;
    logic [7:0]        eff_levels;
    logic [7:0]        clamp_lvl;
    logic [LVL_W-1:0]  enq_lvl;
    logic              enq_full;
    logic              enq_ok;
    logic [SLOT_W-1:0] wr_slot;
    t_desc             wr_desc;

    // Dequeue path
    logic              deq_found;
    logic [LVL_W-1:0]  deq_lvl;
    logic              deq_ok;
    logic [SLOT_W-1:0] rd_slot;

    t_s1_ctrl          n_s1;
    logic [M_TDATA_W-1:0] n_out_tdata;

    // Output may move when empty or taken; read stage moves in behind it
    assign s1_advance      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_enq          = (i_s_axis_tuser[0] == FUNC_ENQ);
    assign is_deq          = (i_s_axis_tuser[0] == FUNC_DEQ);

    assign o_cfg_ready     = 1'b1;

    // Clamp requested priority into the levels in use
    assign prio_req = i_s_axis_tdata[S_PRIO_LO +: PRIO_W];

    always_comb begin
        if (r_active_levels == '0) begin
            eff_levels = 8'd1;
        end else if ({4'b0, r_active_levels} > 8'(MAX_LEVELS)) begin
            eff_levels = 8'(MAX_LEVELS);
        end else begin
            eff_levels = {4'b0, r_active_levels};
        end

        if (prio_req[PRIO_W-1]) begin
            clamp_lvl = 8'd0;
        end else if (prio_req >= eff_levels) begin
            clamp_lvl = eff_levels - 8'd1;
        end else begin
            clamp_lvl = prio_req;
        end
    end

    assign enq_lvl  = clamp_lvl[LVL_W-1:0];
    assign enq_full = (r_fill[enq_lvl] == FILL_W'(LEVEL_DEPTH));
    assign enq_ok   = accept && is_enq && !enq_full;
    assign wr_slot  = SLOT_W'(enq_lvl) * SLOT_W'(LEVEL_DEPTH) + SLOT_W'(r_tail[enq_lvl]);

    always_comb begin
        wr_desc.prio     = prio_req;
        wr_desc.src_addr = i_s_axis_tdata[S_SRCA_LO  +: ADDR_W];
        wr_desc.src_port = i_s_axis_tdata[S_SRCP_LO  +: PORT_W];
        wr_desc.dst_addr = i_s_axis_tdata[S_DSTA_LO  +: ADDR_W];
        wr_desc.dst_port = i_s_axis_tdata[S_DSTP_LO  +: PORT_W];
        wr_desc.proto    = i_s_axis_tdata[S_PROTO_LO +: PROTO_W];
    end

    // Lowest non-empty level wins; scan covers every level, so levels
    // stranded above a lowered active_levels still drain
    always_comb begin
        deq_found = 1'b0;
        deq_lvl   = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (r_fill[i] != '0) begin
                deq_found = 1'b1;
                deq_lvl   = LVL_W'(i);
            end
        end
    end

    assign deq_ok  = accept && is_deq && deq_found;
    assign rd_slot = SLOT_W'(deq_lvl) * SLOT_W'(LEVEL_DEPTH) + SLOT_W'(r_head[deq_lvl]);

    // Status and level for the read stage
    always_comb begin
        if (is_enq) begin
            n_s1.status = enq_full ? ST_DROPPED : ST_ENQUEUED;
            n_s1.level  = LEVEL_W'(clamp_lvl);
        end else if (deq_found) begin
            n_s1.status = ST_DEQUEUED;
            n_s1.level  = LEVEL_W'({{(8 - LVL_W){1'b0}}, deq_lvl});
        end else begin
            n_s1.status = ST_EMPTY;
            n_s1.level  = '0;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_levels <= CFG_LEVELS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_levels <= i_cfg_data;
        end
    end

    // Pointer and fill count update; at most one command per cycle, so at most
    // one level changes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (enq_ok) begin
            r_tail[enq_lvl] <= (r_tail[enq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                               '0 : r_tail[enq_lvl] + PTR_W'(1);
            r_fill[enq_lvl] <= r_fill[enq_lvl] + FILL_W'(1);
        end else if (deq_ok) begin
            r_head[deq_lvl] <= (r_head[deq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                               '0 : r_head[deq_lvl] + PTR_W'(1);
            r_fill[deq_lvl] <= r_fill[deq_lvl] - FILL_W'(1);
        end
    end

    // Store: write on enqueue, registered read on dequeue
    always_ff @(posedge i_clk) begin
        if (enq_ok) begin
            r_store[wr_slot] <= wr_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deq_ok) begin
            r_rd_data <= r_store[rd_slot];
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // Format the result: descriptor fields only for a dequeued entry
    always_comb begin
        n_out_tdata = '0;
        n_out_tdata[M_LEVEL_LO +: LEVEL_W] = r_s1.level;
        if (r_s1.status == ST_DEQUEUED) begin
            n_out_tdata[M_PRIO_LO  +: PRIO_W]  = r_rd_data.prio;
            n_out_tdata[M_SRCA_LO  +: ADDR_W]  = r_rd_data.src_addr;
            n_out_tdata[M_SRCP_LO  +: PORT_W]  = r_rd_data.src_port;
            n_out_tdata[M_DSTA_LO  +: ADDR_W]  = r_rd_data.dst_addr;
            n_out_tdata[M_DSTP_LO  +: PORT_W]  = r_rd_data.dst_port;
            n_out_tdata[M_PROTO_LO +: PROTO_W] = r_rd_data.proto;
            n_out_tdata[M_ESC_BIT]             = (r_rd_data.prio == '0);
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= r_s1.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

endmodule

`default_nettype wire

@@ hw/rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// Strict-priority packet queues: port checker
// Watches the result stream for protocol and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [spq_pkg::M_TDATA_W-1:0]  i_m_axis_tdata,
    input  wire logic [spq_pkg::M_TUSER_W-1:0]  i_m_axis_tuser
);
    import spq_pkg::*;

    // Result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("result changed while stalled");

    // Enqueue results carry only the level
    a_enq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid &&
        (i_m_axis_tuser == ST_ENQUEUED || i_m_axis_tuser == ST_DROPPED) |->
            i_m_axis_tdata[M_TDATA_W-1:M_PRIO_LO] == '0)
        else $error("enqueue result carries descriptor bits");

    // All-empty result is all zero
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == ST_EMPTY |-> i_m_axis_tdata == '0)
        else $error("empty result not zero");

    // Escalate follows the original priority
    a_escalate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == ST_DEQUEUED |->
            i_m_axis_tdata[M_ESC_BIT] == (i_m_axis_tdata[M_PRIO_LO +: PRIO_W] == '0))
        else $error("escalate does not match priority");

endmodule

bind strict_priority_packet_queues spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strict-priority packet queues: self-checking testbench
// Drives enqueue and dequeue transactions with random pacing and back-pressure.
// A scoreboard keeps its own per-level descriptor queues and checks each
// result field by field. active_levels is swept across many settings,
// including 0 and 15.
// ----------------------------------------------------------------------------

module tb;
    import spq_pkg::*;

    localparam int QUEUE_LEVELS     = MAX_LEVELS_DEF;
    localparam int QUEUE_DEPTH      = LEVEL_DEPTH_DEF;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_ITEMS     = 1150;
    localparam int NUM_SETTINGS     = 14;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TIMEOUT_NS       = 4_000_000;

    // One expected result transaction
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LEVEL_W-1:0] level;
        logic               escalate;
        t_desc              desc;
    } t_queue_result;

    // ------------------------------------------------------------------------
    // Scoreboard: per-level descriptor queues and the results they imply
    // ------------------------------------------------------------------------
    class t_spq_scoreboard;
        t_desc             level_q[QUEUE_LEVELS][$];
        t_queue_result     expected_q[$];
        logic [CFG_W-1:0]  active_levels;
        int                failures;
        int                n_commands;
        int                n_status[4];
        int                n_escalated;

        function new();
            active_levels = CFG_LEVELS_RST;
            failures      = 0;
            n_commands    = 0;
            n_escalated   = 0;
            n_status      = '{0, 0, 0, 0};
        endfunction

        function void set_levels(input logic [CFG_W-1:0] value);
            active_levels = value;
        endfunction

        // 0 behaves as 1, anything above the level count as the level count
        function int levels_in_use();
            if (active_levels == 0)
                return 1;
            if (active_levels > QUEUE_LEVELS)
                return QUEUE_LEVELS;
            return int'(active_levels);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted command transaction
        function void note_command(input logic func, input logic [S_TDATA_W-1:0] data);
            t_queue_result res;
            t_desc         d;
            logic [7:0]    praw;
            int            n;
            int            lvl;
            bit            found;

            res  = '0;
            praw = data[S_PRIO_LO +: PRIO_W];
            n_commands++;
            if (func == FUNC_ENQ) begin
                n = levels_in_use();
                if (praw[7])
                    lvl = 0;
                else if (int'(praw) >= n)
                    lvl = n - 1;
                else
                    lvl = int'(praw);
                res.level = lvl[LEVEL_W-1:0];
                if (level_q[lvl].size() >= QUEUE_DEPTH) begin
                    res.status = ST_DROPPED;
                end else begin
                    d.prio     = praw;
                    d.src_addr = data[S_SRCA_LO +: ADDR_W];
                    d.src_port = data[S_SRCP_LO +: PORT_W];
                    d.dst_addr = data[S_DSTA_LO +: ADDR_W];
                    d.dst_port = data[S_DSTP_LO +: PORT_W];
                    d.proto    = data[S_PROTO_LO +: PROTO_W];
                    level_q[lvl].push_back(d);
                    res.status = ST_ENQUEUED;
                end
            end else begin
                // Scan every level, stranded ones above active_levels too
                res.status = ST_EMPTY;
                found      = 1'b0;
                for (lvl = 0; lvl < QUEUE_LEVELS; lvl++) begin
                    if (!found && level_q[lvl].size() != 0) begin
                        found        = 1'b1;
                        d            = level_q[lvl].pop_front();
                        res.status   = ST_DEQUEUED;
                        res.level    = lvl[LEVEL_W-1:0];
                        res.desc     = d;
                        res.escalate = (d.prio == 8'd0);
                    end
                end
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        // Check one accepted result transaction against the oldest expectation
        function void check_result(input logic [M_TUSER_W-1:0] tuser,
                                   input logic [M_TDATA_W-1:0] tdata);
            t_queue_result want;

            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual %0h/%h",
                         $time, tuser, tdata);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(tuser));
            compare_field("level", 32'(want.level), 32'(tdata[M_LEVEL_LO +: LEVEL_W]));
            compare_field("out_priority", 32'(want.desc.prio),
                          32'(tdata[M_PRIO_LO +: PRIO_W]));
            compare_field("out_src_addr", want.desc.src_addr, tdata[M_SRCA_LO +: ADDR_W]);
            compare_field("out_src_port", 32'(want.desc.src_port),
                          32'(tdata[M_SRCP_LO +: PORT_W]));
            compare_field("out_dst_addr", want.desc.dst_addr, tdata[M_DSTA_LO +: ADDR_W]);
            compare_field("out_dst_port", 32'(want.desc.dst_port),
                          32'(tdata[M_DSTP_LO +: PORT_W]));
            compare_field("out_proto", 32'(want.desc.proto),
                          32'(tdata[M_PROTO_LO +: PROTO_W]));
            compare_field("escalate", 32'(want.escalate), 32'(tdata[M_ESC_BIT]));
            compare_field("padding", 32'd0, 32'(tdata[M_TDATA_W-1:M_ESC_BIT+1]));
            n_status[want.status]++;
            if (want.escalate)
                n_escalated++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    logic                  hold_off_pending;
    logic [CFG_W-1:0]      level_plan [0:NUM_SETTINGS-1];
    int                    burst_left;
    t_spq_scoreboard       sb;

    strict_priority_packet_queues dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side: check every accepted result at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tuser, m_tdata);
    end

    // Receiver stall pattern: modes from always ready to mostly stalled, plus
    // one long hold-off on request so that the block backs up into its input
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;

        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_pending === 1'b1 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = ($urandom_range(0, 1) != 0);
                    default: m_tready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------------

    // Offer one command and hold it until the transaction completes
    task automatic send_command(input logic func, input logic [S_TDATA_W-1:0] data);
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = data;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_command(func, data);
        @(negedge clk);
    endtask

    task automatic send_enqueue(input logic [7:0] prio, input logic [31:0] src_addr,
                                input logic [15:0] src_port, input logic [31:0] dst_addr,
                                input logic [15:0] dst_port, input logic [7:0] proto);
        send_command(FUNC_ENQ, {proto, dst_port, dst_addr, src_port, src_addr, prio});
    endtask

    // Dequeue with junk in the descriptor fields, which the block ignores
    task automatic send_dequeue();
        send_command(FUNC_DEQ, S_TDATA_W'({$urandom, $urandom, $urandom, $urandom}));
    endtask

    // Close a burst at random and idle the sender for a random gap
    task automatic pace_sender();
        int gap;

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_levels(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_port();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Priority mostly on the focus level, sometimes out of range either way
    function automatic logic [7:0] pick_prio(input int n, input int focus, input bit noisy);
        int sel;

        sel = noisy ? $urandom_range(0, 3) : $urandom_range(0, 9);
        case (sel)
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(128, 255));
            2:       return 8'($urandom_range(n, 127));
            3:       return 8'($urandom_range(0, n - 1));
            default: return 8'(focus);
        endcase
    endfunction

    // Random phase: segments that fill one level, drain, mix or add noise
    task automatic run_phase(input int items);
        int n;
        int done;
        int seg_left;
        int seg_kind;
        int focus;
        int deq_pct;

        n        = sb.levels_in_use();
        done     = 0;
        seg_left = 0;
        seg_kind = 0;
        focus    = 0;
        while (done < items) begin
            if (seg_left == 0) begin
                seg_kind = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 40);
                focus    = $urandom_range(0, n - 1);
            end
            case (seg_kind)
                0:       deq_pct = 10;
                1:       deq_pct = 85;
                default: deq_pct = 50;
            endcase
            if ($urandom_range(0, 99) < deq_pct)
                send_dequeue();
            else
                send_enqueue(pick_prio(n, focus, seg_kind == 3), $urandom, rand_port(),
                             $urandom, rand_port(), 8'($urandom_range(0, 255)));
            pace_sender();
            seg_left--;
            done++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;

        level_plan = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd2, 4'd9,
                       4'd3, 4'd12, 4'd6, 4'd5, 4'd7, 4'd1, 4'd8};
        sb               = new();
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = FUNC_ENQ;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        hold_off_pending = 1'b0;
        burst_left       = 0;

        // Hold reset, then release it at a falling edge
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty dequeue, clamping at the extremes, escalation,
        // strict order of service, then empty again
        send_dequeue();
        send_enqueue(8'h00, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_enqueue(8'h80, 32'h0, 16'h0, 32'h0, 16'h0, 8'h00);
        send_enqueue(8'h7F, 32'hA5A5_5A5A, 16'h1234, 32'h5A5A_A5A5, 16'hFEDC, 8'h11);
        send_enqueue(8'h07, 32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd443, 8'd6);
        send_enqueue(8'h08, 32'h0A00_0002, 16'd53, 32'hC0A8_0002, 16'd53, 8'd17);
        send_enqueue(8'hFF, 32'h0102_0304, 16'h8000, 32'h0506_0708, 16'h0001, 8'h80);
        send_enqueue(8'h03, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 8'd1);
        send_enqueue(8'h01, 32'hDEAD_0000, 16'h7FFF, 32'h0000_BEEF, 16'h0000, 8'hFE);
        for (k = 0; k < 9; k++)
            send_dequeue();

        // Random phases, one level setting each; descriptors left in upper
        // levels when the setting drops are served after the lower ones
        for (k = 0; k < NUM_SETTINGS; k++) begin
            wait_idle();
            write_levels(level_plan[k]);
            if (k == 1)
                hold_off_pending = 1'b1;
            run_phase(RANDOM_ITEMS / NUM_SETTINGS);
        end
        wait_idle();

        $display("Covered %0d commands over %0d active_levels settings from 0 to 15,",
                 sb.n_commands, NUM_SETTINGS);
        $display("with %0d enqueued, %0d dropped, %0d dequeued (%0d escalated), %0d empty.",
                 sb.n_status[ST_ENQUEUED], sb.n_status[ST_DROPPED],
                 sb.n_status[ST_DEQUEUED], sb.n_escalated, sb.n_status[ST_EMPTY]);
        if (sb.failures == 0)
            $display("** strict_priority_packet_queues: PASSED **");
        else
            $display("** strict_priority_packet_queues: FAILED **");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #TIMEOUT_NS;
        $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
        $display("** strict_priority_packet_queues: FAILED **");
        $finish;
    end

endmodule
